>>> hw/rtl/sbha_pkg.sv
// sbha_pkg: types, constants and register codes of the spatial bin histogram accumulator
// no dependencies; imported by the configuration interface, the bin store and the top level

package sbha_pkg;

  // bin store geometry
  localparam int unsigned MaxX = 256;
  localparam int unsigned MaxY = 256;
  localparam longint unsigned StoreDepth = 64'(MaxX) * 64'(MaxY);
  localparam int unsigned AddrW = $clog2(StoreDepth);

  // full address x*row_length + y: 8-bit x times 9-bit row plus 8-bit y
  localparam int unsigned FullAddrW = 18;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CfgXLow       = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgXHigh      = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgRowLength  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgExonEnable = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgNarrow     = 3'd4;
  localparam int unsigned CfgDataW = 9;

  localparam logic [8:0] XLowReset      = 9'd0;
  localparam logic [8:0] XHighReset     = 9'd256;
  localparam logic [8:0] RowLengthReset = 9'd256;

  typedef logic [AddrW-1:0] addr_t;

  typedef struct packed {
    logic [31:0] count_sum;
    logic [31:0] item_count;
    logic [31:0] exon_sum;
  } bin_word_t;

  typedef struct packed {
    logic      en;
    addr_t     addr;
    bin_word_t data;
  } store_wr_t;

  typedef struct packed {
    logic  en;
    addr_t addr;
  } store_rd_t;

  typedef struct packed {
    logic        accepted;
    logic [31:0] bin_count_sum;
    logic [31:0] bin_item_count;
    logic [31:0] bin_exon_sum;
    logic [31:0] max_item_count;
    logic [31:0] max_exon_sum;
  } result_t;

  typedef enum logic [1:0] {
    StClear,
    StIdle,
    StUpdate
  } state_e;

  // counter add, wrapping at 16 bits in narrow mode
  function automatic logic [31:0] wrap_add(logic [31:0] a, logic [31:0] b, logic narrow);
    logic [31:0] s;
    s = a + b;
    if (narrow) begin
      s = {16'h0000, s[15:0]};
    end
    return s;
  endfunction

endpackage

>>> hw/rtl/sbha_in_if.sv
// sbha_in_if: record channel into the accumulator, valid/ready with the record fields
// depends on nothing but the handshake convention of the project

interface sbha_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  x_coord;
  logic [7:0]  y_coord;
  logic [15:0] read_count;
  logic [15:0] exon_count;

  modport source (output valid, x_coord, y_coord, read_count, exon_count, input ready);
  modport sink   (input valid, x_coord, y_coord, read_count, exon_count, output ready);
endinterface

>>> hw/rtl/sbha_out_if.sv
// sbha_out_if: result channel out of the accumulator, valid/ready with the result fields
// depends on nothing but the handshake convention of the project

interface sbha_out_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [31:0] bin_count_sum;
  logic [31:0] bin_item_count;
  logic [31:0] bin_exon_sum;
  logic [31:0] max_item_count;
  logic [31:0] max_exon_sum;

  modport source (output valid, accepted, bin_count_sum, bin_item_count, bin_exon_sum,
                  max_item_count, max_exon_sum, input ready);
  modport sink   (input valid, accepted, bin_count_sum, bin_item_count, bin_exon_sum,
                  max_item_count, max_exon_sum, output ready);
endinterface

>>> hw/rtl/sbha_cfg_if.sv
// sbha_cfg_if: configuration write channel, valid/ready with register index and data
// widths from sbha_pkg

interface sbha_cfg_if;
  import sbha_pkg::*;

  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/sbha_bin_store.sv
// sbha_bin_store: bin memory holding count sum, item count and exon sum per bin
// one write port, one read port with registered read data; types from sbha_pkg

module sbha_bin_store (
  input  logic                  clk_i,
  input  sbha_pkg::store_wr_t   wr_i,
  input  sbha_pkg::store_rd_t   rd_i,
  output sbha_pkg::bin_word_t   rdata_o
);
  import sbha_pkg::*;

  bin_word_t mem_q [StoreDepth];
  bin_word_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rdata_q <= mem_q[rd_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/spatial_bin_histogram_accumulator.sv
// spatial_bin_histogram_accumulator: top level, config registers, update sequencer, maxima
// uses sbha_pkg, sbha_in_if, sbha_out_if, sbha_cfg_if and sbha_bin_store

// After reset the block runs a clearing pass over all StoreDepth (65536) bins of the store,
// one bin per cycle, during which no record is taken; configuration writes are taken at
// any time. After that the transfer cycle of each record reads the addressed bin from the
// single-port-read store, and the update state adds, writes the bin back and loads the
// output register. A record is taken whenever the sequencer is idle,
// even while the previous result still waits in the output register; the update cycle
// waits only if that register is still full. Records outside the x stripe, or whose
// address x*row_length+y falls beyond the store, give a result with accepted low and
// zero bin fields. Configuration must be written only while no record is in flight.

module spatial_bin_histogram_accumulator (
  input  logic        clk_i,
  input  logic        rst_ni,
  sbha_in_if.sink     in_i,
  sbha_out_if.source  out_o,
  sbha_cfg_if.sink    cfg_i
);
  import sbha_pkg::*;

  // configuration registers
  logic [8:0] x_low_q, x_high_q, row_length_q;
  logic       exon_enable_q, narrow_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_low_q       <= XLowReset;
      x_high_q      <= XHighReset;
      row_length_q  <= RowLengthReset;
      exon_enable_q <= 1'b0;
      narrow_q      <= 1'b0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CfgXLow:       x_low_q       <= cfg_i.data;
        CfgXHigh:      x_high_q      <= cfg_i.data;
        CfgRowLength:  row_length_q  <= cfg_i.data;
        CfgExonEnable: exon_enable_q <= cfg_i.data[0];
        CfgNarrow:     narrow_q      <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // sequencer state
  state_e      state_q, state_d;
  addr_t       clr_addr_q;
  logic        out_valid_q, out_valid_d;
  result_t     out_q, out_d;
  logic [31:0] max_items_q, max_items_d;
  logic [31:0] max_exons_q, max_exons_d;

  // record held between the read and the update cycle
  logic        hit_q;
  addr_t       addr_q;
  logic [15:0] cnt_q, exn_q;

  store_wr_t   wr;
  store_rd_t   rd;
  bin_word_t   rdata;

  logic        in_xfer, out_free, do_update;

  // address and stripe check on the incoming record
  logic [FullAddrW-1:0] full_addr;
  logic                 in_stripe, addr_ok, hit;

  assign full_addr = FullAddrW'(in_i.x_coord) * FullAddrW'(row_length_q)
                   + FullAddrW'(in_i.y_coord);
  assign addr_ok   = 64'(full_addr) < StoreDepth;
  assign in_stripe = ({1'b0, in_i.x_coord} >= x_low_q) && ({1'b0, in_i.x_coord} < x_high_q);
  assign hit       = in_stripe && addr_ok;

  assign in_xfer   = in_i.valid && in_i.ready;
  assign out_free  = !out_valid_q || out_o.ready;
  assign do_update = (state_q == StUpdate) && out_free;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StClear: begin
        if (clr_addr_q == addr_t'(StoreDepth - 1)) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (in_i.valid) begin
          state_d = StUpdate;
        end
      end
      StUpdate: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StClear;
    endcase
  end

  // updated bin values from the read data
  logic [31:0] csum, icnt, esum;
  bin_word_t   new_word;

  always_comb begin
    csum = wrap_add(rdata.count_sum, {16'h0000, cnt_q}, narrow_q);
    icnt = wrap_add(rdata.item_count, 32'd1, narrow_q);
    esum = exon_enable_q ? wrap_add(rdata.exon_sum, {16'h0000, exn_q}, narrow_q) : 32'd0;
    new_word.count_sum  = csum;
    new_word.item_count = icnt;
    new_word.exon_sum   = exon_enable_q ? esum : rdata.exon_sum;
  end

  // outputs of the sequencer
  always_comb begin
    in_i.ready  = (state_q == StIdle);
    rd.en       = in_xfer;
    rd.addr     = addr_t'(full_addr);
    wr.en       = 1'b0;
    wr.addr     = addr_q;
    wr.data     = new_word;
    out_valid_d = out_valid_q && !out_o.ready;
    out_d       = out_q;
    max_items_d = max_items_q;
    max_exons_d = max_exons_q;
    case (state_q)
      StClear: begin
        wr.en   = 1'b1;
        wr.addr = clr_addr_q;
        wr.data = '0;
      end
      StUpdate: begin
        if (do_update) begin
          wr.en = hit_q;
          if (hit_q && (icnt > max_items_q)) begin
            max_items_d = icnt;
          end
          if (hit_q && exon_enable_q && (esum > max_exons_q)) begin
            max_exons_d = esum;
          end
          out_valid_d          = 1'b1;
          out_d.accepted       = hit_q;
          out_d.bin_count_sum  = hit_q ? csum : 32'd0;
          out_d.bin_item_count = hit_q ? icnt : 32'd0;
          out_d.bin_exon_sum   = hit_q ? esum : 32'd0;
          out_d.max_item_count = max_items_d;
          out_d.max_exon_sum   = max_exons_d;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
      max_items_q <= '0;
      max_exons_q <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      max_items_q <= max_items_d;
      max_exons_q <= max_exons_d;
      if (state_q == StClear) begin
        clr_addr_q <= clr_addr_q + addr_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (in_xfer) begin
      hit_q  <= hit;
      addr_q <= addr_t'(full_addr);
      cnt_q  <= in_i.read_count;
      exn_q  <= in_i.exon_count;
    end
  end

  sbha_bin_store u_store (
    .clk_i   (clk_i),
    .wr_i    (wr),
    .rd_i    (rd),
    .rdata_o (rdata)
  );

  assign out_o.valid          = out_valid_q;
  assign out_o.accepted       = out_q.accepted;
  assign out_o.bin_count_sum  = out_q.bin_count_sum;
  assign out_o.bin_item_count = out_q.bin_item_count;
  assign out_o.bin_exon_sum   = out_q.bin_exon_sum;
  assign out_o.max_item_count = out_q.max_item_count;
  assign out_o.max_exon_sum   = out_q.max_exon_sum;

`ifndef SYNTHESIS
  // the store is written only by the clearing pass or a completing update
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.en |-> (state_q == StClear) || do_update)
    else $error("bin store written outside clear or update");

  // a new result appears only right after an update cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(do_update))
    else $error("result valid without an update");

  // running maxima never fall
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (max_items_q >= $past(max_items_q)) && (max_exons_q >= $past(max_exons_q)))
    else $error("running maximum decreased");
`endif

endmodule
